@@ rtl/xpc_pkg.sv @@
`default_nettype none

package xpc_pkg;

    // Fixed widths of the item fields
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int MP_W   = 5;

    // Queue geometry
    localparam int MAX_LEN         = 64;
    localparam int SLOTS_PER_QUEUE = 8;

    localparam int SLOT_W = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
    localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int CNT_W  = $clog2(SLOTS_PER_QUEUE + 1);
    localparam int TOT_W  = (CNT_W + 1 > MP_W) ? CNT_W + 1 : MP_W;
    localparam int ADDR_W = SLOT_W + POS_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam logic [MP_W-1:0] MAX_PACKETS_RST = MP_W'(16);

    // Result status codes; the drop codes double as the drop state
    localparam logic [STAT_W-1:0] ST_CODED    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd2;
    localparam logic [STAT_W-1:0] ST_TOOLONG  = 2'd3;
    localparam logic [STAT_W-1:0] DROP_NONE   = 2'd0;

    typedef enum logic [2:0] {
        S_IN  = 3'b001,
        S_RD  = 3'b010,
        S_OUT = 3'b100
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take_item;
        logic read_en;
        logic emit_coded;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic code_start;
        logic run_end;
        logic out_free;
    } sts_t;

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        begin
            if (s == SLOT_W'(SLOTS_PER_QUEUE - 1))
            begin
                r = '0;
            end
            else
            begin
                r = s + 1'b1;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/xpc_if.sv @@
`default_nettype none

interface xpc_in_if;
    import xpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              dest;
    logic              last;

    modport source (output valid, output data_byte, output dest, output last, input ready);
    modport sink   (input valid, input data_byte, input dest, input last, output ready);
endinterface

interface xpc_out_if;
    import xpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic [STAT_W-1:0] status;

    modport source (output valid, output out_byte, output out_last, output status, input ready);
    modport sink   (input valid, input out_byte, input out_last, input status, output ready);
endinterface

interface xpc_cfg_if;
    import xpc_pkg::*;

    logic            valid;
    logic            ready;
    logic [MP_W-1:0] max_packets;

    modport source (output valid, output max_packets, input ready);
    modport sink   (input valid, input max_packets, output ready);
endinterface

`default_nettype wire

@@ rtl/xpc_ctrl.sv @@
`default_nettype none

module xpc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  xpc_pkg::sts_t sts,
    output xpc_pkg::cmd_t cmd,
    output logic          busy
);
    import xpc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.take_item  = 1'b0;
        cmd.read_en    = 1'b0;
        cmd.emit_coded = 1'b0;
        case (state_reg)
            S_IN:
            begin
                in_ready      = sts.out_free;
                cmd.take_item = in_valid && sts.out_free;
                if (cmd.take_item && sts.code_start)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.read_en = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_coded = 1'b1;
                    state_next     = sts.run_end ? S_IN : S_RD;
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    assign busy = (state_reg != S_IN);

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/xpc_datapath.sv @@
`default_nettype none

module xpc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [xpc_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        dest,
    input  logic                        last,
    input  xpc_pkg::cmd_t               cmd,
    output xpc_pkg::sts_t               sts,
    input  logic                        cfg_valid,
    input  logic [xpc_pkg::MP_W-1:0]    cfg_data,
    output logic                        cfg_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [xpc_pkg::BYTE_W-1:0]  out_byte,
    output logic                        out_last,
    output logic [xpc_pkg::STAT_W-1:0]  status
);
    import xpc_pkg::*;

    // Configuration
    logic [MP_W-1:0] max_packets_reg;

    // Queue bookkeeping
    logic [SLOT_W-1:0] head_reg [2];
    logic [SLOT_W-1:0] tail_reg [2];
    logic [CNT_W-1:0]  cnt_reg  [2];
    logic [LEN_W-1:0]  len_arr_reg [2][SLOTS_PER_QUEUE];

    // Packet being assembled
    logic [LEN_W-1:0]  asm_len_reg;
    logic              asm_dest_reg;
    logic [STAT_W-1:0] drop_reg;

    // Coded run
    logic [SLOT_W-1:0] slot0_reg;
    logic [SLOT_W-1:0] slot1_reg;
    logic [LEN_W-1:0]  run_len_reg;
    logic [POS_W-1:0]  idx_reg;

    // Payload stores, one per queue
    logic [BYTE_W-1:0] mem0_reg [MEM_DEPTH];
    logic [BYTE_W-1:0] mem1_reg [MEM_DEPTH];
    logic [BYTE_W-1:0] rd0_reg;
    logic [BYTE_W-1:0] rd1_reg;

    // Output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic [STAT_W-1:0] status_reg;

    logic              first;
    logic              q;
    logic              other;
    logic [TOT_W-1:0]  total;
    logic              full;
    logic [STAT_W-1:0] drop_in;
    logic [STAT_W-1:0] drop_eff;
    logic              wr_en;
    logic [LEN_W-1:0]  len_inc;
    logic              commit;
    logic              pair;
    logic              match;
    logic              load_status;
    logic [ADDR_W-1:0] wr_addr;

    // Classify the arriving byte
    always_comb
    begin
        first    = (drop_reg == DROP_NONE) && (asm_len_reg == '0);
        q        = first ? dest : asm_dest_reg;
        other    = ~q;
        total    = TOT_W'(cnt_reg[0]) + TOT_W'(cnt_reg[1]);
        full     = (total >= TOT_W'(max_packets_reg))
                   || (cnt_reg[dest] >= CNT_W'(SLOTS_PER_QUEUE));
        drop_in  = first ? (full ? ST_FULL : DROP_NONE) : drop_reg;
        if ((drop_in == DROP_NONE) && (asm_len_reg >= LEN_W'(MAX_LEN)))
        begin
            drop_eff = ST_TOOLONG;
        end
        else
        begin
            drop_eff = drop_in;
        end
        len_inc  = asm_len_reg + 1'b1;
        wr_en    = cmd.take_item && (drop_eff == DROP_NONE);
        wr_addr  = {tail_reg[q], asm_len_reg[POS_W-1:0]};
        commit   = wr_en && last;
        // The arriving queue was empty, so its head is the packet just finished
        match    = (len_arr_reg[other][head_reg[other]] == len_inc);
        pair     = commit && (cnt_reg[other] != '0);
        load_status = cmd.take_item && last
                      && ((drop_eff != DROP_NONE) || (pair && !match));
    end

    assign sts.code_start = last && (drop_eff == DROP_NONE)
                            && (cnt_reg[other] != '0) && match;
    assign sts.run_end    = (LEN_W'(idx_reg) + 1'b1 == run_len_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // Hold the limit register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packets_reg <= MAX_PACKETS_RST;
        end
        else if (cfg_valid)
        begin
            max_packets_reg <= cfg_data;
        end
    end

    // Track assembly, drops and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_len_reg  <= '0;
            asm_dest_reg <= 1'b0;
            drop_reg     <= DROP_NONE;
            head_reg[0]  <= '0;
            head_reg[1]  <= '0;
            tail_reg[0]  <= '0;
            tail_reg[1]  <= '0;
            cnt_reg[0]   <= '0;
            cnt_reg[1]   <= '0;
        end
        else if (cmd.take_item)
        begin
            if (first)
            begin
                asm_dest_reg <= dest;
            end
            if (last)
            begin
                drop_reg    <= DROP_NONE;
                asm_len_reg <= '0;
            end
            else
            begin
                drop_reg <= drop_eff;
                if (wr_en)
                begin
                    asm_len_reg <= len_inc;
                end
            end
            if (commit)
            begin
                tail_reg[q] <= slot_next(tail_reg[q]);
                if (pair)
                begin
                    head_reg[0]    <= slot_next(head_reg[0]);
                    head_reg[1]    <= slot_next(head_reg[1]);
                    cnt_reg[other] <= cnt_reg[other] - 1'b1;
                end
                else
                begin
                    cnt_reg[q] <= cnt_reg[q] + 1'b1;
                end
            end
        end
    end

    // File the length of a finished packet
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            len_arr_reg[q][tail_reg[q]] <= len_inc;
        end
    end

    // Latch the pair to be coded and step through it
    always_ff @(posedge clk)
    begin
        if (cmd.take_item && sts.code_start)
        begin
            slot0_reg   <= head_reg[0];
            slot1_reg   <= head_reg[1];
            run_len_reg <= len_inc;
            idx_reg     <= '0;
        end
        else if (cmd.emit_coded)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Queue 0 payload store
    always_ff @(posedge clk)
    begin
        if (wr_en && !q)
        begin
            mem0_reg[wr_addr] <= data_byte;
        end
        if (cmd.read_en)
        begin
            rd0_reg <= mem0_reg[{slot0_reg, idx_reg}];
        end
    end

    // Queue 1 payload store
    always_ff @(posedge clk)
    begin
        if (wr_en && q)
        begin
            mem1_reg[wr_addr] <= data_byte;
        end
        if (cmd.read_en)
        begin
            rd1_reg <= mem1_reg[{slot1_reg, idx_reg}];
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_status || cmd.emit_coded)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load_status)
        begin
            out_byte_reg <= '0;
            out_last_reg <= 1'b1;
            status_reg   <= (drop_eff != DROP_NONE) ? drop_eff : ST_MISMATCH;
        end
        else if (cmd.emit_coded)
        begin
            out_byte_reg <= rd0_reg ^ rd1_reg;
            out_last_reg <= sts.run_end;
            status_reg   <= ST_CODED;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

@@ rtl/xor_pair_packet_coder.sv @@
`default_nettype none

// Channel   Role  Beat contents
// in_ch     sink  data_byte, dest (taken on first byte), last
// out_ch    src   out_byte, out_last, status
// cfg_ch    sink  max_packets (always ready)
//
// An input byte is accepted whenever no coded run is in progress and the output register is free.
// The last byte of a packet that pairs with a matching head starts a coded
// run: each coded byte is a payload store read, then an output load, with the
// input held off until the run's last beat is loaded.
// Reset clears the queues and sets max_packets to 16; no clearing pass.
// A stalled output holds its beat and back-pressures the input.
module xor_pair_packet_coder (
    input  logic      clk,
    input  logic      rst_n,
    xpc_in_if.sink    in_ch,
    xpc_out_if.source out_ch,
    xpc_cfg_if.sink   cfg_ch
);
    import xpc_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy;

    xpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    xpc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (in_ch.data_byte),
        .dest      (in_ch.dest),
        .last      (in_ch.last),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_ch.valid),
        .cfg_data  (cfg_ch.max_packets),
        .cfg_ready (cfg_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_byte  (out_ch.out_byte),
        .out_last  (out_ch.out_last),
        .status    (out_ch.status)
    );

    // No input while a coded run is in progress
    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ch.ready)
        else $error("input ready during coded run");

    // Coded beats load only into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_coded |-> (!out_ch.valid || out_ch.ready))
        else $error("coded beat overwrites pending output");

    // A store read is always followed by a coded emit phase
    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_en |=> (busy && !cmd.read_en))
        else $error("read not followed by emit phase");

    // Status results are single-beat runs carrying a zero byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status != ST_CODED))
        |-> (out_ch.out_last && (out_ch.out_byte == '0)))
        else $error("status result not a lone zero beat");

endmodule

`default_nettype wire
